[hw/rtl/afsr_pkg.sv]
// Shared types and constants for the audio frame sample-rate control block.
// Field widths, register indexes, register reset values and the request struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package afsr_pkg;

   localparam int FILL_W    = 20;
   localparam int SPF_W     = 32;
   localparam int FRAC_W    = 16;
   localparam int SAMPLES_W = 17;
   localparam int ADJ_OUT_W = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [SAMPLES_W-1:0] SAMPLES_MAX = '1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_FILL  = 2'd0,
      CSR_HIGH_FILL = 2'd1,
      CSR_SPF_Q16   = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   localparam logic [FILL_W-1:0] LOW_FILL_RESET  = 20'd0;
   localparam logic [FILL_W-1:0] HIGH_FILL_RESET = 20'hFFFFF;
   localparam logic [SPF_W-1:0]  SPF_RESET       = 32'd48168960;

   localparam logic KIND_START = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   typedef struct packed {
      logic              kind;
      logic [FILL_W-1:0] buffered_bytes;
      logic              throttle_on;
   } item_type;

endpackage

`default_nettype wire

[hw/rtl/audio_frame_sample_rate_control.sv]
// Top level of the audio frame sample-rate control block: stream ports,
// register file, request register and response register.
// Depends on afsr_pkg, afsr_adjust_ctrl and afsr_sample_calc.
`timescale 1ns / 1ps
`default_nettype none

// Channel   | direction | handshake                | payload
// ----------+-----------+--------------------------+------------------------------------
// req       | in        | req_tvalid / req_tready  | tuser: kind; tdata: fill, throttle
// rsp       | out       | rsp_tvalid / rsp_tready  | tdata: samples, adjustment
// csr       | in        | csr_valid / csr_ready    | csr_index, csr_data
//
// One request per cycle is sustained while the receiver takes each response; each request
// reaches the response register at the edge that moves it out of the request register.
// The single compute pass runs the run counters and the fraction accumulator.
// Reset is synchronous and clears the pipeline valids, counters and register file.
// A stalled response holds the pipeline; the request register still fills once.
// csr_ready is always high; a write to an unused index is dropped.

module audio_frame_sample_rate_control
   import afsr_pkg::*;
#(
   parameter int MAX_ADJUST    = 16,
   parameter int MID_RUN_LIMIT = 10
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   // request stream
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [23:0]           req_tdata,  // [19:0] buffered_bytes, [20] throttle_on
   input  wire logic                  req_tuser,  // [0] kind
   // response stream
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [23:0]                rsp_tdata,  // [16:0] samples_next_frame, [22:17] adjustment
   // register writes
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [SPF_W-1:0]      csr_data
);

   localparam int ADJ_W = $clog2(MAX_ADJUST + 1) + 1;

   // register file
   logic [FILL_W-1:0] low_fill_ff;
   logic [FILL_W-1:0] high_fill_ff;
   logic [SPF_W-1:0]  spf_ff;

   // request register
   logic     req_valid_ff;
   item_type req_item_ff;

   // response register
   logic                 rsp_valid_ff;
   logic [SAMPLES_W-1:0] rsp_samples_ff;
   logic [ADJ_OUT_W-1:0] rsp_adjust_ff;

   logic                    advance;
   logic                    step;
   logic signed [ADJ_W-1:0] adjust_next;
   logic [SAMPLES_W-1:0]    samples;
   logic signed [31:0]      adjust_ext;

   // advance the compute stage whenever the response slot is free or draining
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign step       = advance && req_valid_ff;
   assign req_tready = !req_valid_ff || advance;
   assign csr_ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_fill_ff  <= LOW_FILL_RESET;
         high_fill_ff <= HIGH_FILL_RESET;
         spf_ff       <= SPF_RESET;
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_LOW_FILL:  low_fill_ff  <= csr_data[FILL_W-1:0];
            CSR_HIGH_FILL: high_fill_ff <= csr_data[FILL_W-1:0];
            CSR_SPF_Q16:   spf_ff       <= csr_data;
            default:       ;
         endcase
      end
   end

   // capture a request whenever the register is empty or moving on
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_tready) begin
         req_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_item_ff.kind           <= req_tuser;
         req_item_ff.buffered_bytes <= req_tdata[FILL_W-1:0];
         req_item_ff.throttle_on    <= req_tdata[FILL_W];
      end
   end

   afsr_adjust_ctrl #(
      .MAX_ADJUST    (MAX_ADJUST),
      .MID_RUN_LIMIT (MID_RUN_LIMIT),
      .ADJ_W         (ADJ_W)
   ) u_adjust (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .item        (req_item_ff),
      .low_fill    (low_fill_ff),
      .high_fill   (high_fill_ff),
      .adjust_next (adjust_next)
   );

   afsr_sample_calc #(
      .ADJ_W (ADJ_W)
   ) u_calc (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .kind    (req_item_ff.kind),
      .spf_q16 (spf_ff),
      .adjust  (adjust_next),
      .samples (samples)
   );

   // report the low bits of the adjustment, sign extended when it is narrow
   assign adjust_ext = 32'(adjust_next);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_samples_ff <= samples;
         rsp_adjust_ff  <= adjust_ext[ADJ_OUT_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_adjust_ff, rsp_samples_ff};

endmodule

`default_nettype wire

[hw/rtl/afsr_adjust_ctrl.sv]
// Run counters and signed sample-count adjustment for the rate control block.
// Depends on afsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afsr_adjust_ctrl
   import afsr_pkg::*;
#(
   parameter int MAX_ADJUST    = 16,
   parameter int MID_RUN_LIMIT = 10,
   parameter int ADJ_W         = $clog2(MAX_ADJUST + 1) + 1
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire item_type                item,
   input  wire logic [FILL_W-1:0]       low_fill,
   input  wire logic [FILL_W-1:0]       high_fill,
   output logic signed [ADJ_W-1:0]      adjust_next
);

   localparam int RUN_W = $clog2(MAX_ADJUST + 1);
   localparam int MID_W = $clog2(MID_RUN_LIMIT + 2);
   localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_ADJUST);
   localparam logic [MID_W-1:0] MID_LIM = MID_W'(MID_RUN_LIMIT);

   logic [RUN_W-1:0]        low_run_ff, low_run_in;
   logic [RUN_W-1:0]        high_run_ff, high_run_in;
   logic [MID_W-1:0]        mid_run_ff, mid_run_in;
   logic signed [ADJ_W-1:0] adjust_ff, adjust_in;

   always_comb begin
      low_run_in  = low_run_ff;
      high_run_in = high_run_ff;
      mid_run_in  = mid_run_ff;
      adjust_in   = adjust_ff;
      if (item.kind == KIND_START) begin
         // keep the adjustment, restart the runs
         low_run_in  = '0;
         high_run_in = '0;
         mid_run_in  = '0;
      end else if (!item.throttle_on) begin
         low_run_in  = '0;
         high_run_in = '0;
         mid_run_in  = '0;
         adjust_in   = '0;
      end else if (item.buffered_bytes < low_fill) begin
         if (low_run_ff < RUN_MAX) begin
            low_run_in = low_run_ff + 1'b1;
         end
         mid_run_in  = '0;
         high_run_in = '0;
         adjust_in   = $signed({1'b0, low_run_in});
      end else if (item.buffered_bytes > high_fill) begin
         if (high_run_ff < RUN_MAX) begin
            high_run_in = high_run_ff + 1'b1;
         end
         low_run_in = '0;
         mid_run_in = '0;
         adjust_in  = -$signed({1'b0, high_run_in});
      end else begin
         low_run_in  = '0;
         high_run_in = '0;
         if (mid_run_ff <= MID_LIM) begin
            mid_run_in = mid_run_ff + 1'b1;
         end
         if (mid_run_in > MID_LIM) begin
            adjust_in = '0;
         end
      end
   end

   assign adjust_next = adjust_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_run_ff  <= '0;
         high_run_ff <= '0;
         mid_run_ff  <= '0;
         adjust_ff   <= '0;
      end else if (step) begin
         low_run_ff  <= low_run_in;
         high_run_ff <= high_run_in;
         mid_run_ff  <= mid_run_in;
         adjust_ff   <= adjust_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/afsr_sample_calc.sv]
// Fraction accumulator and saturated sample count for the rate control block.
// Depends on afsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module afsr_sample_calc
   import afsr_pkg::*;
#(
   parameter int ADJ_W = 6
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire logic                    kind,
   input  wire logic [SPF_W-1:0]        spf_q16,
   input  wire logic signed [ADJ_W-1:0] adjust,
   output logic [SAMPLES_W-1:0]         samples
);

   localparam int BASE_W = SPF_W - FRAC_W + 1;
   localparam int TOT_W  = ((ADJ_W > BASE_W) ? ADJ_W : BASE_W) + 2;

   logic [FRAC_W-1:0]       fraction_ff, fraction_in;
   logic [SPF_W:0]          acc;
   logic [BASE_W-1:0]       base;
   logic signed [TOT_W-1:0] total;

   always_comb begin
      acc = {1'b0, spf_q16} + (SPF_W + 1)'(fraction_ff);
      if (kind == KIND_START) begin
         fraction_in = spf_q16[FRAC_W-1:0];
         base        = {1'b0, spf_q16[SPF_W-1:FRAC_W]};
         total       = TOT_W'($signed({1'b0, base}));
      end else begin
         fraction_in = acc[FRAC_W-1:0];
         base        = acc[SPF_W:FRAC_W];
         total       = TOT_W'($signed({1'b0, base})) + TOT_W'(adjust);
      end
      // clamp at zero below, all ones above
      if (total < 0) begin
         samples = '0;
      end else if (total > $signed(TOT_W'(SAMPLES_MAX))) begin
         samples = SAMPLES_MAX;
      end else begin
         samples = total[SAMPLES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fraction_ff <= '0;
      end else if (step) begin
         fraction_ff <= fraction_in;
      end
   end

endmodule

`default_nettype wire

[hw/rtl/afsr_checker.sv]
// Port-level checks for audio_frame_sample_rate_control, bound to the top level.
// Depends on afsr_pkg and the top level's ports.
`timescale 1ns / 1ps
`default_nettype none

module afsr_checker
   import afsr_pkg::*;
#(
   parameter int MAX_ADJUST = 16
) (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   localparam logic signed [7:0] ADJ_HI = 8'(MAX_ADJUST);

   logic signed [7:0] adj_seen;
   assign adj_seen = 8'($signed(rsp_tdata[22:17]));

   // a held response stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   // backpressure on requests only when the response side stalls
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("request stalled without response backpressure");

   // nothing offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("response valid after reset");

   // adjustment stays within its bound when it fits the field
   a_adj_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (MAX_ADJUST < 32) |-> adj_seen <= ADJ_HI && adj_seen >= -ADJ_HI)
      else $error("adjustment out of range");

endmodule

bind audio_frame_sample_rate_control afsr_checker #(
   .MAX_ADJUST (MAX_ADJUST)
) u_afsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

[tb/sv/afsr_sample_checker.sv]
`timescale 1ns / 1ps
// Checker for the audio frame sample-rate control block: it watches the request,
// response and register channels, predicts each response and compares it.
// Depends on afsr_pkg.

module afsr_sample_checker
   import afsr_pkg::*;
#(
   parameter int MAX_ADJUST    = 16,
   parameter int MID_RUN_LIMIT = 10
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tready,
   input  logic [23:0]          req_tdata,  // [19:0] buffered_bytes, [20] throttle_on
   input  logic                 req_tuser,  // [0] kind
   input  logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   input  logic [23:0]          rsp_tdata,  // [16:0] samples_next_frame, [22:17] adjustment
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SPF_W-1:0]     csr_data,
   output int                   error_count,
   output int                   pending_count
);

   typedef struct packed {
      logic [ADJ_OUT_W-1:0] adjustment;
      logic [SAMPLES_W-1:0] samples;
   } frame_answer_type;

   frame_answer_type  expected_answers[$];

   logic [FILL_W-1:0] low_fill;
   logic [FILL_W-1:0] high_fill;
   logic [SPF_W-1:0]  spf_q16;
   int                low_run;
   int                mid_run;
   int                high_run;
   int                adjust_now;
   logic [FRAC_W-1:0] fraction_acc;

   // Advance the predicted state by one request and queue the answer it gives.
   task automatic predict_frame_answer(input logic kind, input logic [FILL_W-1:0] fill,
                                       input logic throttled);
      logic [SPF_W:0]   acc_sum;
      int               total;
      frame_answer_type answer;
      if (kind == KIND_START) begin
         low_run      = 0;
         mid_run      = 0;
         high_run     = 0;
         fraction_acc = spf_q16[FRAC_W-1:0];
         total        = int'(spf_q16[SPF_W-1:FRAC_W]);
      end else begin
         if (!throttled) begin
            low_run    = 0;
            mid_run    = 0;
            high_run   = 0;
            adjust_now = 0;
         end else if (fill < low_fill) begin
            // a fill below low wins even when the thresholds cross
            if (low_run < MAX_ADJUST) low_run++;
            mid_run    = 0;
            high_run   = 0;
            adjust_now = low_run;
         end else if (fill > high_fill) begin
            if (high_run < MAX_ADJUST) high_run++;
            low_run    = 0;
            mid_run    = 0;
            adjust_now = -high_run;
         end else begin
            low_run  = 0;
            high_run = 0;
            if (mid_run <= MID_RUN_LIMIT) mid_run++;
            if (mid_run > MID_RUN_LIMIT) adjust_now = 0;
         end
         acc_sum      = spf_q16 + fraction_acc;
         fraction_acc = acc_sum[FRAC_W-1:0];
         total        = int'(acc_sum[SPF_W:FRAC_W]) + adjust_now;
      end
      if (total < 0) total = 0;
      if (total > int'(SAMPLES_MAX)) total = int'(SAMPLES_MAX);
      answer.samples    = total[SAMPLES_W-1:0];
      answer.adjustment = adjust_now[ADJ_OUT_W-1:0];
      expected_answers.push_back(answer);
   endtask

   always @(posedge clock) begin
      frame_answer_type seen;
      frame_answer_type want;
      if (reset) begin
         low_fill     = LOW_FILL_RESET;
         high_fill    = HIGH_FILL_RESET;
         spf_q16      = SPF_RESET;
         low_run      = 0;
         mid_run      = 0;
         high_run     = 0;
         adjust_now   = 0;
         fraction_acc = '0;
         error_count  = 0;
         expected_answers.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.samples    = rsp_tdata[SAMPLES_W-1:0];
            seen.adjustment = rsp_tdata[SAMPLES_W +: ADJ_OUT_W];
            if (expected_answers.size() == 0) begin
               $error("response with no request waiting: samples_next_frame %0d, adjustment %0d",
                      seen.samples, $signed(seen.adjustment));
               error_count++;
            end else begin
               want = expected_answers.pop_front();
               if (seen.samples !== want.samples) begin
                  $error("samples_next_frame: expected %0d, actual %0d",
                         want.samples, seen.samples);
                  error_count++;
               end
               if (seen.adjustment !== want.adjustment) begin
                  $error("adjustment: expected %0d, actual %0d",
                         $signed(want.adjustment), $signed(seen.adjustment));
                  error_count++;
               end
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_LOW_FILL:  low_fill  = csr_data[FILL_W-1:0];
               CSR_HIGH_FILL: high_fill = csr_data[FILL_W-1:0];
               CSR_SPF_Q16:   spf_q16   = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            predict_frame_answer(req_tuser, req_tdata[FILL_W-1:0], req_tdata[FILL_W]);
      end
      pending_count = expected_answers.size();
   end

endmodule

[tb/sv/audio_frame_sample_rate_control_tb.sv]
`timescale 1ns / 1ps
// Testbench top for audio_frame_sample_rate_control: clock, reset, request and
// register stimulus, response back-pressure, watchdog and verdict.
// Depends on afsr_pkg, the block itself and afsr_sample_checker.

module audio_frame_sample_rate_control_tb;
   import afsr_pkg::*;

   localparam int MAX_ADJUST     = 16;
   localparam int MID_RUN_LIMIT  = 10;
   localparam int RESET_CYCLES   = 5;
   localparam int RSP_LATENCY    = 4;     // two register stages plus margin
   localparam int LONG_HOLD      = 300;   // receiver hold-off under pressure
   localparam int WATCHDOG_LIMIT = 4000;  // cycles without any handshake
   localparam int FILL_MAX       = 2**FILL_W - 1;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 85;

   typedef enum int {
      SEG_LOW,
      SEG_HIGH,
      SEG_MID,
      SEG_NO_THROTTLE,
      SEG_NOISE,
      SEG_START
   } segment_kind_type;

   // Drive every input to a known value from time zero.
   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic [23:0]          req_tdata  = '0;
   logic                 req_tuser  = 1'b0;
   logic                 rsp_tready = 1'b0;
   logic                 csr_valid  = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [SPF_W-1:0]     csr_data   = '0;
   logic                 req_tready;
   logic                 rsp_tvalid;
   logic [23:0]          rsp_tdata;
   logic                 csr_ready;
   int                   error_count;
   int                   pending_count;

   // Sender shaping and receiver hold-off control.
   int                   burst_left       = 0;
   bit                   steady_sender    = 1'b0;
   bit                   hold_off_pending = 1'b0;
   logic [FILL_W-1:0]    cur_low;
   logic [FILL_W-1:0]    cur_high;
   int                   stall_cycles     = 0;

   always #10 clock = ~clock;

   audio_frame_sample_rate_control #(
      .MAX_ADJUST    (MAX_ADJUST),
      .MID_RUN_LIMIT (MID_RUN_LIMIT)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   afsr_sample_checker #(
      .MAX_ADJUST    (MAX_ADJUST),
      .MID_RUN_LIMIT (MID_RUN_LIMIT)
   ) checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   // Watchdog: end the run when no channel has moved anything for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Response sink: stall on patterns that are chosen anew at random, and
   // hold off for a long stretch whenever the stimulus asks for it.
   initial begin : rsp_sink
      int mode;
      int left;
      mode = 0;
      left = 0;
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD - 1) @(posedge clock);
         end else begin
            if (left == 0) begin
               mode = $urandom_range(0, 3);
               left = $urandom_range(8, 80);
            end
            left--;
            case (mode)
               0:       rsp_tready <= 1'b1;                       // no stalls
               1:       rsp_tready <= 1'($urandom_range(0, 1));   // coin toss
               2:       rsp_tready <= ($urandom_range(0, 3) != 0);
               default: rsp_tready <= ((left % 8) < 3);           // periodic stall
            endcase
         end
      end
   end

   // Offer one request and return at the edge that accepts it. Open a random
   // gap first whenever the current burst is used up. Sample ready at the
   // falling edge so the decision never races the block's own update.
   task automatic offer_request(input logic kind, input logic [FILL_W-1:0] fill,
                                input logic throttled);
      logic taken;
      int   gap;
      if (burst_left == 0) begin
         gap        = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, throttled, fill};
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Drop valid and hold until every predicted response has come back.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_count != 0);
      repeat (RSP_LATENCY) @(posedge clock);
   endtask

   // Hold one register write until it is taken; valid is lowered by the caller.
   task automatic write_reg(input csr_index_type idx, input logic [SPF_W-1:0] value);
      logic taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Write all three registers while the block is idle; now and then also
   // hit the unused index, which must be dropped.
   task automatic load_settings(input logic [FILL_W-1:0] low, input logic [FILL_W-1:0] high,
                                input logic [SPF_W-1:0] spf);
      write_reg(CSR_LOW_FILL, {12'd0, low});
      write_reg(CSR_HIGH_FILL, {12'd0, high});
      write_reg(CSR_SPF_Q16, spf);
      if ($urandom_range(0, 3) == 0) write_reg(CSR_UNUSED, $urandom);
      csr_valid <= 1'b0;
      cur_low  = low;
      cur_high = high;
   endtask

   // Choose thresholds and rate: typical, wide open, crossed, random, equal;
   // rate near normal, tiny (negative sums), fully random, zero or all ones.
   task automatic pick_settings();
      int               lo;
      int               hi;
      logic [SPF_W-1:0] spf;
      case ($urandom_range(0, 4))
         0: begin
            lo = $urandom_range(0, 4000);
            hi = lo + $urandom_range(0, 8000);
         end
         1: begin
            lo = 0;
            hi = FILL_MAX;
         end
         2: begin
            lo = FILL_MAX;
            hi = 0;
         end
         3: begin
            lo = $urandom_range(0, FILL_MAX);
            hi = $urandom_range(0, FILL_MAX);
         end
         default: begin
            lo = $urandom_range(0, FILL_MAX);
            hi = lo;
         end
      endcase
      case ($urandom_range(0, 4))
         0, 1:    spf = {16'($urandom_range(700, 820)), 16'($urandom)};
         2:       spf = {16'($urandom_range(0, 20)), 16'($urandom)};
         3:       spf = $urandom;
         default: spf = ($urandom_range(0, 1) != 0) ? '0 : '1;
      endcase
      load_settings(lo[FILL_W-1:0], hi[FILL_W-1:0], spf);
   endtask

   // Pick a fill that lands in the wanted band; fall back to any value when
   // the current thresholds leave that band empty.
   function automatic logic [FILL_W-1:0] pick_fill(input segment_kind_type seg);
      logic [FILL_W-1:0] fill;
      fill = FILL_W'($urandom);
      case (seg)
         SEG_LOW:
            if (cur_low != 0)
               fill = ($urandom_range(0, 2) == 0) ? cur_low - 1'b1
                                                  : FILL_W'($urandom_range(int'(cur_low) - 1, 0));
         SEG_HIGH:
            if (cur_high != FILL_W'(FILL_MAX))
               fill = ($urandom_range(0, 2) == 0) ? cur_high + 1'b1
                                                  : FILL_W'($urandom_range(FILL_MAX,
                                                                           int'(cur_high) + 1));
         SEG_MID:
            if (cur_low <= cur_high)
               fill = FILL_W'($urandom_range(int'(cur_high), int'(cur_low)));
         default: ;
      endcase
      return fill;
   endfunction

   // Mostly runs of lows, highs and in-band fills so the counters climb,
   // saturate and clear; the rest is throttle-off, noise and restarts.
   task automatic run_random_phase(input int n_items);
      int               sent;
      int               run_len;
      int               pick;
      segment_kind_type seg;
      sent = 0;
      offer_request(KIND_START, FILL_W'($urandom), 1'($urandom));
      sent++;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 30)      seg = SEG_LOW;
         else if (pick < 55) seg = SEG_HIGH;
         else if (pick < 80) seg = SEG_MID;
         else if (pick < 87) seg = SEG_NO_THROTTLE;
         else if (pick < 95) seg = SEG_NOISE;
         else                seg = SEG_START;
         case (seg)
            SEG_LOW, SEG_HIGH: run_len = $urandom_range(1, 20);
            SEG_MID:           run_len = $urandom_range(1, 14);
            default:           run_len = $urandom_range(1, 3);
         endcase
         repeat (run_len) begin
            case (seg)
               SEG_NO_THROTTLE: offer_request(KIND_FRAME, FILL_W'($urandom), 1'b0);
               SEG_NOISE:       offer_request(1'($urandom), FILL_W'($urandom), 1'($urandom));
               SEG_START:       offer_request(KIND_START, FILL_W'($urandom), 1'($urandom));
               default:         offer_request(KIND_FRAME, pick_fill(seg), 1'b1);
            endcase
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: climb to the top of the low run and saturate there, step
      // to a high, hit both thresholds exactly, drop throttle, restart.
      load_settings(20'd1000, 20'd5000, {16'd735, 16'h8000});
      offer_request(KIND_START, 20'hFFFFF, 1'b0);
      repeat (16) offer_request(KIND_FRAME, 20'd0, 1'b1);
      offer_request(KIND_FRAME, 20'd999, 1'b1);
      offer_request(KIND_FRAME, 20'd5001, 1'b1);
      offer_request(KIND_FRAME, 20'd1000, 1'b1);
      offer_request(KIND_FRAME, 20'd5000, 1'b1);
      offer_request(KIND_FRAME, 20'd0, 1'b0);
      offer_request(KIND_START, 20'd0, 1'b1);

      // Crossed thresholds at the extremes with the largest rate.
      wait_for_drain();
      load_settings(20'hFFFFF, 20'd0, 32'hFFFF_FFFF);
      offer_request(KIND_FRAME, 20'h7FFFF, 1'b1);
      offer_request(KIND_FRAME, 20'hFFFFF, 1'b1);
      offer_request(KIND_START, 20'h12345, 1'b1);

      // Tiny rate with a run of highs: push base plus adjustment below zero.
      wait_for_drain();
      load_settings(20'd0, 20'd0, {16'd2, 16'hFFFF});
      offer_request(KIND_START, 20'd0, 1'b1);
      repeat (4) offer_request(KIND_FRAME, 20'hFFFFF, 1'b1);

      // Random phases; one of them runs the sender flat out against a long
      // receiver hold-off so the block fills up and stalls its input.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_for_drain();
         pick_settings();
         steady_sender = (phase == 2 || phase == 4);
         if (phase == 4) hold_off_pending = 1'b1;
         run_random_phase(PHASE_ITEMS);
      end

      wait_for_drain();
      repeat (RSP_LATENCY) @(negedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
